// ===== rtl/ttf_pkg.sv =====
// ttf_pkg: shared types and constants for the triangle tangent frame block
// no dependencies; imported by ttf_front, ttf_norm, ttf_back and triangle_tangent_frame
package ttf_pkg;

  // vertices per triangle
  localparam int unsigned TRI_VERTS  = 3;
  // the largest aligned magnitude lands in [2^(ALIGN_BITS-1), 2^ALIGN_BITS)
  localparam int unsigned ALIGN_BITS = 30;
  // components below one part in TINY_SCALE are flushed to zero
  localparam longint unsigned TINY_SCALE = 64'd10000000;

  // field order of a triangle record, first field in the top bits
  localparam int NUM_FIELDS = 10;
  localparam int F_DV0X = 0;
  localparam int F_DV0Y = 1;
  localparam int F_DV0Z = 2;
  localparam int F_DV1X = 3;
  localparam int F_DV1Y = 4;
  localparam int F_DV1Z = 5;
  localparam int F_DT0U = 6;
  localparam int F_DT0V = 7;
  localparam int F_DT1U = 8;
  localparam int F_DT1V = 9;

  typedef enum logic [2:0] {
    B_IDLE, B_MUL, B_CHECK, B_NORM_T, B_NORM_B, B_OUT
  } back_state_e;

  typedef enum logic [2:0] {
    N_IDLE, N_ALIGN, N_SQ, N_SQRT, N_DLOAD, N_DIV, N_DONE
  } norm_state_e;

  typedef struct packed {
    logic start;
    logic flip;
  } norm_ctrl_t;

  typedef struct packed {
    logic done;
    logic zero;
  } norm_stat_t;

endpackage

// ===== rtl/ttf_front.sv =====
// ttf_front: takes vertices, tracks the triangle phase and the two held vertices
// on the third vertex of a triangle it pushes the edge and uv deltas; uses ttf_pkg
module ttf_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           in_valid_i,
  output logic                                           in_stall_o,
  input  logic                                           new_shape_i,
  input  logic signed [COORD_WIDTH-1:0]                  pos_x_i,
  input  logic signed [COORD_WIDTH-1:0]                  pos_y_i,
  input  logic signed [COORD_WIDTH-1:0]                  pos_z_i,
  input  logic signed [COORD_WIDTH-1:0]                  tex_u_i,
  input  logic signed [COORD_WIDTH-1:0]                  tex_v_i,
  input  logic                                           full_i,
  output logic                                           push_o,
  output logic [ttf_pkg::NUM_FIELDS*(COORD_WIDTH+1)-1:0] rec_o
);
  import ttf_pkg::*;

  localparam int DW = COORD_WIDTH + 1;

  logic                          accept;
  logic [1:0]                    phase_q, phase_d, ph;
  logic                          third;
  logic signed [COORD_WIDTH-1:0] hp0_q [3];
  logic signed [COORD_WIDTH-1:0] hp1_q [3];
  logic signed [COORD_WIDTH-1:0] ht0_q [2];
  logic signed [COORD_WIDTH-1:0] ht1_q [2];
  logic signed [COORD_WIDTH-1:0] pos [3];
  logic signed [COORD_WIDTH-1:0] tex [2];
  logic signed [DW-1:0]          dv0 [3];
  logic signed [DW-1:0]          dv1 [3];
  logic signed [DW-1:0]          dt0 [2];
  logic signed [DW-1:0]          dt1 [2];

  assign pos = '{pos_x_i, pos_y_i, pos_z_i};
  assign tex = '{tex_u_i, tex_v_i};

  // stall only while the queue has no room
  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;

  // phase after a possible restart, and whether this vertex closes a triangle
  always_comb begin
    ph      = new_shape_i ? 2'd0 : phase_q;
    third   = ({1'b0, ph} + 3'd1) >= 3'(TRI_VERTS);
    phase_d = third ? 2'd0 : ph + 2'd1;
    push_o  = accept & third;
  end

  // deltas against the oldest held vertex, one bit wider than the inputs
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv0[i] = {hp1_q[i][COORD_WIDTH-1], hp1_q[i]} - {hp0_q[i][COORD_WIDTH-1], hp0_q[i]};
      dv1[i] = {pos[i][COORD_WIDTH-1], pos[i]} - {hp0_q[i][COORD_WIDTH-1], hp0_q[i]};
    end
    for (int i = 0; i < 2; i++) begin
      dt0[i] = {ht1_q[i][COORD_WIDTH-1], ht1_q[i]} - {ht0_q[i][COORD_WIDTH-1], ht0_q[i]};
      dt1[i] = {tex[i][COORD_WIDTH-1], tex[i]} - {ht0_q[i][COORD_WIDTH-1], ht0_q[i]};
    end
    rec_o = {dv0[0], dv0[1], dv0[2], dv1[0], dv1[1], dv1[2],
             dt0[0], dt0[1], dt1[0], dt1[1]};
  end

  // phase and vertex history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        hp0_q[i] <= '0;
        hp1_q[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        ht0_q[i] <= '0;
        ht1_q[i] <= '0;
      end
    end else if (accept) begin
      phase_q <= phase_d;
      for (int i = 0; i < 3; i++) begin
        hp0_q[i] <= hp1_q[i];
        hp1_q[i] <= pos[i];
      end
      for (int i = 0; i < 2; i++) begin
        ht0_q[i] <= ht1_q[i];
        ht1_q[i] <= tex[i];
      end
    end
  end

endmodule

// ===== rtl/ttf_queue.sv =====
// ttf_queue: two-entry queue of triangle records between front and back
// no package dependencies
module ttf_queue #(
  parameter int WIDTH = 330
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

// ===== rtl/ttf_norm.sv =====
// ttf_norm: sequential normalize unit, one vector of three wide components
// align, sum of squares, bit-serial square root and divide; uses ttf_pkg
module ttf_norm #(
  parameter int COORD_WIDTH   = 32,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  ttf_pkg::norm_ctrl_t                     ctrl_i,
  input  logic signed [2*COORD_WIDTH+2:0]         vec_i [3],
  output ttf_pkg::norm_stat_t                     stat_o,
  output logic signed [OUT_FRAC_BITS+1:0]         q_o [3]
);
  import ttf_pkg::*;

  localparam int PW = 2 * COORD_WIDTH + 3;
  localparam int OW = OUT_FRAC_BITS + 2;
  localparam int QW = OUT_FRAC_BITS + 1;
  localparam int SW = 2 * ALIGN_BITS + 3;
  localparam int NW = ALIGN_BITS + OUT_FRAC_BITS + 1;
  localparam int LW = ALIGN_BITS + 1;
  localparam int KW = $clog2(QW + 1);
  localparam logic [QW-1:0] TinyLim =
    QW'(((64'd1 << OUT_FRAC_BITS) + TINY_SCALE - 64'd1) / TINY_SCALE);

  norm_state_e state_q, state_d;

  logic [PW-1:0]           a_q [3];
  logic                    neg_q [3];
  logic                    flip_q, zero_q;
  logic [PW-1:0]           orv;
  logic [ALIGN_BITS-1:0]   c [3];
  logic [1:0]              cnt_q;
  logic [2*ALIGN_BITS-1:0] sq_q;
  logic [SW-1:0]           len2_q, num_q, res_q, bit_q, trial;
  logic [LW-1:0]           len;
  logic [NW-1:0]           rem_q, d_q;
  logic [QW-1:0]           quo_q, qn, m;
  logic [KW-1:0]           k_q;
  logic [1:0]              ci_q;
  logic                    qbit, last_k;
  logic signed [OW-1:0]    q_q [3];

  always_comb begin
    orv = a_q[0] | a_q[1] | a_q[2];
    for (int i = 0; i < 3; i++) c[i] = a_q[i][ALIGN_BITS-1:0];
    len    = res_q[LW-1:0];
    trial  = res_q + bit_q;
    qbit   = rem_q >= d_q;
    qn     = {quo_q[QW-2:0], qbit};
    m      = (qn < TinyLim) ? '0 : qn;
    last_k = k_q == KW'(QW - 1);
  end

  // sequencer, a new vector may start in the done cycle
  always_comb begin
    state_d = state_q;
    case (state_q)
      N_IDLE, N_DONE: state_d = ctrl_i.start ? N_ALIGN : N_IDLE;
      N_ALIGN: begin
        if (orv == '0) state_d = N_DONE;
        else if ((orv >> ALIGN_BITS) == '0 && (orv >> (ALIGN_BITS - 1)) != '0)
          state_d = N_SQ;
      end
      N_SQ:    if (cnt_q == 2'd3) state_d = N_SQRT;
      N_SQRT:  if (bit_q == '0) state_d = N_DLOAD;
      N_DLOAD: state_d = N_DIV;
      N_DIV: begin
        if (last_k) state_d = (ci_q == 2'd2) ? N_DONE : N_DLOAD;
      end
      default: state_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= N_IDLE;
    else state_q <= state_d;
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      N_IDLE, N_DONE: begin
        if (ctrl_i.start) begin
          flip_q <= ctrl_i.flip;
          zero_q <= 1'b0;
          for (int i = 0; i < 3; i++) begin
            neg_q[i] <= vec_i[i][PW-1];
            a_q[i]   <= vec_i[i][PW-1] ? (~vec_i[i] + 1'b1) : vec_i[i];
          end
        end
      end
      // common shift of all three magnitudes, coarse steps first
      N_ALIGN: begin
        cnt_q  <= 2'd0;
        len2_q <= '0;
        if (orv == '0) begin
          zero_q <= 1'b1;
        end else if ((orv >> (ALIGN_BITS + 8)) != '0) begin
          for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] >> 8;
        end else if ((orv >> ALIGN_BITS) != '0) begin
          for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] >> 1;
        end else if ((orv >> (ALIGN_BITS - 8)) == '0) begin
          for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] << 8;
        end else if ((orv >> (ALIGN_BITS - 1)) == '0) begin
          for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] << 1;
        end
      end
      // one square per cycle, accumulated in the following cycle
      N_SQ: begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q != 2'd3) sq_q <= c[cnt_q] * c[cnt_q];
        if (cnt_q != 2'd0) len2_q <= len2_q + SW'(sq_q);
        if (cnt_q == 2'd3) begin
          num_q <= len2_q + SW'(sq_q);
          res_q <= '0;
          bit_q <= SW'(1) << (2 * ALIGN_BITS + 2);
        end
      end
      // integer square root, one result bit per cycle
      N_SQRT: begin
        if (bit_q != '0) begin
          if (num_q >= trial) begin
            num_q <= num_q - trial;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end
        ci_q <= 2'd0;
      end
      // rounded numerator for the current component
      N_DLOAD: begin
        rem_q <= (NW'(c[ci_q]) << OUT_FRAC_BITS) + NW'(len >> 1);
        d_q   <= NW'(len) << OUT_FRAC_BITS;
        quo_q <= '0;
        k_q   <= '0;
      end
      // restoring divide, one quotient bit per cycle
      N_DIV: begin
        if (qbit) rem_q <= rem_q - d_q;
        d_q   <= d_q >> 1;
        quo_q <= qn;
        k_q   <= k_q + 1'b1;
        if (last_k) begin
          q_q[ci_q] <= (neg_q[ci_q] ^ flip_q) ? -OW'(m) : OW'(m);
          ci_q      <= ci_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign stat_o.done = state_q == N_DONE;
  assign stat_o.zero = zero_q;
  assign q_o         = q_q;

endmodule

// ===== rtl/ttf_back.sv =====
// ttf_back: pops triangle records, forms determinant and frame vectors with one
// shared multiplier, normalizes them and holds the result; uses ttf_pkg, ttf_norm
module ttf_back #(
  parameter int COORD_WIDTH   = 32,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           empty_i,
  input  logic [ttf_pkg::NUM_FIELDS*(COORD_WIDTH+1)-1:0] rec_i,
  output logic                                           pop_o,
  output logic                                           out_valid_o,
  input  logic                                           out_stall_i,
  output logic signed [OUT_FRAC_BITS+1:0]                tangent_x_o,
  output logic signed [OUT_FRAC_BITS+1:0]                tangent_y_o,
  output logic signed [OUT_FRAC_BITS+1:0]                tangent_z_o,
  output logic signed [OUT_FRAC_BITS+1:0]                bitangent_x_o,
  output logic signed [OUT_FRAC_BITS+1:0]                bitangent_y_o,
  output logic signed [OUT_FRAC_BITS+1:0]                bitangent_z_o,
  output logic                                           degenerate_o
);
  import ttf_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW + 1;
  localparam int OW = OUT_FRAC_BITS + 2;
  localparam logic [3:0] MulSteps = 4'd14;

  back_state_e state_q, state_d;

  logic signed [DW-1:0]   fld [NUM_FIELDS];
  logic signed [DW-1:0]   op_a, op_b;
  logic signed [2*DW-1:0] mul_q, first_q;
  logic signed [PW-1:0]   res_q [7];
  logic signed [PW-1:0]   vec [3];
  logic [3:0]             step_q, k;
  logic                   det_zero, load_out, take_t, take_b;
  logic signed [OW-1:0]   tq_q [3];
  logic signed [OW-1:0]   bq_q [3];
  logic signed [OW-1:0]   nq [3];
  logic                   degen_q, out_valid_q;
  norm_ctrl_t             nctrl;
  norm_stat_t             nstat;

  // unpack the queue head
  always_comb begin
    for (int f = 0; f < NUM_FIELDS; f++) begin
      fld[f] = rec_i[(NUM_FIELDS - f) * DW - 1 -: DW];
    end
  end

  // operand schedule: determinant, then tangent, then bitangent pairs
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step_q)
      4'd0:  begin op_a = fld[F_DT0U]; op_b = fld[F_DT1V]; end
      4'd1:  begin op_a = fld[F_DT1U]; op_b = fld[F_DT0V]; end
      4'd2:  begin op_a = fld[F_DV0X]; op_b = fld[F_DT1V]; end
      4'd3:  begin op_a = fld[F_DV1X]; op_b = fld[F_DT0V]; end
      4'd4:  begin op_a = fld[F_DV0Y]; op_b = fld[F_DT1V]; end
      4'd5:  begin op_a = fld[F_DV1Y]; op_b = fld[F_DT0V]; end
      4'd6:  begin op_a = fld[F_DV0Z]; op_b = fld[F_DT1V]; end
      4'd7:  begin op_a = fld[F_DV1Z]; op_b = fld[F_DT0V]; end
      4'd8:  begin op_a = fld[F_DV1X]; op_b = fld[F_DT0U]; end
      4'd9:  begin op_a = fld[F_DV0X]; op_b = fld[F_DT1U]; end
      4'd10: begin op_a = fld[F_DV1Y]; op_b = fld[F_DT0U]; end
      4'd11: begin op_a = fld[F_DV0Y]; op_b = fld[F_DT1U]; end
      4'd12: begin op_a = fld[F_DV1Z]; op_b = fld[F_DT0U]; end
      4'd13: begin op_a = fld[F_DV0Z]; op_b = fld[F_DT1U]; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign k        = step_q - 4'd1;
  assign det_zero = res_q[0] == '0;

  // normalize unit input: tangent first, bitangent once the tangent is done
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vec[i] = (state_q == B_NORM_T) ? res_q[4 + i] : res_q[1 + i];
    end
  end

  // control
  always_comb begin
    state_d     = state_q;
    pop_o       = 1'b0;
    nctrl.start = 1'b0;
    nctrl.flip  = ~res_q[0][PW-1];
    load_out    = 1'b0;
    take_t      = 1'b0;
    take_b      = 1'b0;
    case (state_q)
      B_IDLE: if (!empty_i) state_d = B_MUL;
      B_MUL: begin
        if (step_q == MulSteps) begin
          pop_o   = 1'b1;
          state_d = B_CHECK;
        end
      end
      B_CHECK: begin
        if (det_zero) begin
          state_d = B_OUT;
        end else begin
          nctrl.start = 1'b1;
          state_d     = B_NORM_T;
        end
      end
      B_NORM_T: begin
        if (nstat.done) begin
          take_t = 1'b1;
          if (nstat.zero) begin
            state_d = B_OUT;
          end else begin
            nctrl.start = 1'b1;
            state_d     = B_NORM_B;
          end
        end
      end
      B_NORM_B: begin
        if (nstat.done) begin
          take_b  = 1'b1;
          state_d = B_OUT;
        end
      end
      B_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_MUL) step_q <= step_q + 4'd1;
      else step_q <= 4'd0;
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // products, then pairwise differences in the cycle after the second product
  always_ff @(posedge clk_i) begin
    if (state_q == B_MUL) begin
      mul_q <= op_a * op_b;
      if (step_q != 4'd0) begin
        if (!k[0]) first_q <= mul_q;
        else res_q[k[3:1]] <= {first_q[2*DW-1], first_q} - {mul_q[2*DW-1], mul_q};
      end
    end
    if (state_q == B_CHECK) degen_q <= det_zero;
    if (take_t) begin
      tq_q <= nq;
      if (nstat.zero) degen_q <= 1'b1;
    end
    if (take_b) begin
      bq_q    <= nq;
      degen_q <= nstat.zero;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      tangent_x_o   <= degen_q ? '0 : tq_q[0];
      tangent_y_o   <= degen_q ? '0 : tq_q[1];
      tangent_z_o   <= degen_q ? '0 : tq_q[2];
      bitangent_x_o <= degen_q ? '0 : bq_q[0];
      bitangent_y_o <= degen_q ? '0 : bq_q[1];
      bitangent_z_o <= degen_q ? '0 : bq_q[2];
      degenerate_o  <= degen_q;
    end
  end

  assign out_valid_o = out_valid_q;

  ttf_norm #(
    .COORD_WIDTH  (COORD_WIDTH),
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_norm (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(nctrl),
    .vec_i (vec),
    .stat_o(nstat),
    .q_o   (nq)
  );

endmodule

// ===== rtl/triangle_tangent_frame.sv =====
// Triangle tangent frame: vertex stream in, one unit tangent and bitangent out
// per triangle. Input channel (in_valid_i / in_stall_o) carries one vertex per
// transaction: position and texture coordinate in signed Q16.16 plus a
// new_shape flag that restarts the triangle phase. Every third vertex of a
// shape closes a triangle; the other vertices only update the held history.
// Output channel (out_valid_o / out_stall_i) carries one transaction per
// triangle: tangent and bitangent in signed Q2.14 and a degenerate flag.
// Vertices are taken one per cycle while the two-entry triangle queue has
// room. Per triangle the back end picks up the record, forms the 14 shared
// products and checks the determinant, then per vector aligns, squares,
// takes the bit-serial square root, runs the three divides and hands over,
// and finally loads the result; normalizing is skipped when the uv
// determinant is zero, and the bitangent when the tangent vanishes.
// A held result stays on the outputs while out_stall_i is high; the back end
// meanwhile finishes the next triangle and waits, and the front keeps taking
// vertices until the queue fills.
// Reset clears the phase, the held vertices, the queue and the output valid.
// Depends on ttf_pkg, ttf_front, ttf_queue, ttf_back.
module triangle_tangent_frame #(
  parameter int COORD_WIDTH   = 32,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          new_shape_i,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_z_i,
  input  logic signed [COORD_WIDTH-1:0] tex_u_i,
  input  logic signed [COORD_WIDTH-1:0] tex_v_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [OUT_FRAC_BITS+1:0] tangent_x_o,
  output logic signed [OUT_FRAC_BITS+1:0] tangent_y_o,
  output logic signed [OUT_FRAC_BITS+1:0] tangent_z_o,
  output logic signed [OUT_FRAC_BITS+1:0] bitangent_x_o,
  output logic signed [OUT_FRAC_BITS+1:0] bitangent_y_o,
  output logic signed [OUT_FRAC_BITS+1:0] bitangent_z_o,
  output logic                          degenerate_o
);
  import ttf_pkg::*;

  localparam int RW = NUM_FIELDS * (COORD_WIDTH + 1);

  logic          push, pop, full, empty;
  logic [RW-1:0] rec_in, rec_out;

  ttf_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .new_shape_i(new_shape_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pos_z_i    (pos_z_i),
    .tex_u_i    (tex_u_i),
    .tex_v_i    (tex_v_i),
    .full_i     (full),
    .push_o     (push),
    .rec_o      (rec_in)
  );

  ttf_queue #(
    .WIDTH(RW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (rec_in),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (rec_out)
  );

  ttf_back #(
    .COORD_WIDTH  (COORD_WIDTH),
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .rec_i        (rec_out),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .tangent_x_o  (tangent_x_o),
    .tangent_y_o  (tangent_y_o),
    .tangent_z_o  (tangent_z_o),
    .bitangent_x_o(bitangent_x_o),
    .bitangent_y_o(bitangent_y_o),
    .bitangent_z_o(bitangent_z_o),
    .degenerate_o (degenerate_o)
  );

endmodule

// ===== rtl/ttf_checker.sv =====
// ttf_checker: port-level checks of the triangle tangent frame outputs
// bound to triangle_tangent_frame; no package dependencies
module ttf_checker #(
  parameter int COORD_WIDTH   = 32,
  parameter int OUT_FRAC_BITS = 14
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic signed [OUT_FRAC_BITS+1:0] tangent_x_o,
  input logic signed [OUT_FRAC_BITS+1:0] tangent_y_o,
  input logic signed [OUT_FRAC_BITS+1:0] tangent_z_o,
  input logic signed [OUT_FRAC_BITS+1:0] bitangent_x_o,
  input logic signed [OUT_FRAC_BITS+1:0] bitangent_y_o,
  input logic signed [OUT_FRAC_BITS+1:0] bitangent_z_o,
  input logic                            degenerate_o
);

  localparam int Unit = 1 << OUT_FRAC_BITS;
  localparam int Cw   = COORD_WIDTH;

  // a stalled result transaction stays valid and keeps tangent_x, bitangent_z and degenerate
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tangent_x_o)
      && $stable(bitangent_z_o) && $stable(degenerate_o))
    else $error("result changed under stall");

  // a degenerate triangle carries zero vectors
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> tangent_x_o == '0 && tangent_y_o == '0
      && tangent_z_o == '0 && bitangent_x_o == '0 && bitangent_y_o == '0
      && bitangent_z_o == '0)
    else $error("degenerate result with nonzero vector");

  // unit components stay within one
  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni || Cw == 0)
    out_valid_o |-> int'(tangent_x_o) <= Unit && int'(tangent_x_o) >= -Unit
      && int'(tangent_y_o) <= Unit && int'(tangent_y_o) >= -Unit
      && int'(tangent_z_o) <= Unit && int'(tangent_z_o) >= -Unit)
    else $error("tangent component out of range");

  a_b_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(bitangent_x_o) <= Unit && int'(bitangent_x_o) >= -Unit
      && int'(bitangent_y_o) <= Unit && int'(bitangent_y_o) >= -Unit
      && int'(bitangent_z_o) <= Unit && int'(bitangent_z_o) >= -Unit)
    else $error("bitangent component out of range");

endmodule

bind triangle_tangent_frame ttf_checker #(
  .COORD_WIDTH  (COORD_WIDTH),
  .OUT_FRAC_BITS(OUT_FRAC_BITS)
) u_ttf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .tangent_x_o  (tangent_x_o),
  .tangent_y_o  (tangent_y_o),
  .tangent_z_o  (tangent_z_o),
  .bitangent_x_o(bitangent_x_o),
  .bitangent_y_o(bitangent_y_o),
  .bitangent_z_o(bitangent_z_o),
  .degenerate_o (degenerate_o)
);

// ===== verif/testbench.sv =====
// testbench: self-checking bench for triangle_tangent_frame, vertex stream in, frames out
// depends on rtl/triangle_tangent_frame.sv (and ttf_pkg underneath); predicts untyped frames itself
module testbench;

  localparam int CW = 32;
  localparam int OW = 16;
  localparam int FRAC = 14;
  localparam int ALIGN = 30;
  localparam longint unsigned TINY = 64'd10000000;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 1150;

  typedef struct {
    logic signed [OW-1:0] tx, ty, tz, bx, by, bz;
    logic                 degen;
  } frame_t;

  typedef struct {
    logic                 ns;
    logic signed [CW-1:0] px, py, pz, tu, tv;
    bit                   typed;
    frame_t               want;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic new_shape = 1'b0;
  logic signed [CW-1:0] pos_x = '0, pos_y = '0, pos_z = '0, tex_u = '0, tex_v = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OW-1:0] tan_x, tan_y, tan_z, bit_x, bit_y, bit_z;
  logic degenerate;

  vertex_t vertices[$];
  frame_t  frames_due[$];
  int      mismatches = 0;
  int      cycles = 0;
  bit      stimulus_done = 1'b0;

  // predictor state
  logic signed [CW-1:0] held_pos[6];
  logic signed [CW-1:0] held_tex[4];
  int                   tri_phase;

  triangle_tangent_frame dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .new_shape_i(new_shape),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .tex_u_i(tex_u), .tex_v_i(tex_v),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .tangent_x_o(tan_x), .tangent_y_o(tan_y), .tangent_z_o(tan_z),
    .bitangent_x_o(bit_x), .bitangent_y_o(bit_y), .bitangent_z_o(bit_z),
    .degenerate_o(degenerate)
  );

  // clock, 20 units
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[triangle_tangent_frame] ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] num);
    logic [63:0] res, b;
    res = '0;
    b = 64'd1 << 62;
    while (b > num) b = b >> 2;
    while (b != 0) begin
      if (num >= res + b) begin
        num = num - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // normalize a wide vector to q2.14, ok is low for a zero vector
  task automatic unit_vector(input logic signed [127:0] v0, v1, v2, input bit flip,
                             output logic signed [OW-1:0] q0, q1, q2, output bit ok);
    logic signed [127:0] v[3];
    logic [127:0]        mag[3];
    bit                  neg[3];
    logic [63:0]         c[3], sq, len, m;
    logic signed [OW-1:0] q[3];
    int                  n, bl, i, k;
    v[0] = v0; v[1] = v1; v[2] = v2;
    n = 0;
    sq = '0;
    for (i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      bl = 0;
      for (k = 0; k < 128; k++) if (mag[i][k]) bl = k + 1;
      if (bl > n) n = bl;
    end
    ok = (n != 0);
    q0 = '0; q1 = '0; q2 = '0;
    if (ok) begin
      for (i = 0; i < 3; i++) begin
        if (n > ALIGN) c[i] = 64'(mag[i] >> (n - ALIGN));
        else c[i] = 64'(mag[i]) << (ALIGN - n);
        sq = sq + c[i] * c[i];
      end
      len = int_sqrt(sq);
      for (i = 0; i < 3; i++) begin
        m = ((c[i] << FRAC) + (len >> 1)) / len;
        if (m * TINY < (64'd1 << FRAC)) m = '0;
        q[i] = (neg[i] != flip) ? -OW'(m) : OW'(m);
      end
      q0 = q[0]; q1 = q[1]; q2 = q[2];
    end
  endtask

  // advance the held history by one vertex; returns 1 with a frame on a closing vertex
  task automatic tangent_frame_of(input vertex_t vx, output bit closes, output frame_t f);
    logic signed [127:0] dv0[3], dv1[3], dt0[2], dt1[2], tv[3], bv[3], det;
    logic signed [CW-1:0] p[3], t[2];
    bit ok_t, ok_b, flip;
    int i;
    p[0] = vx.px; p[1] = vx.py; p[2] = vx.pz;
    t[0] = vx.tu; t[1] = vx.tv;
    f = '{default: '0};
    if (vx.ns) tri_phase = 0;
    closes = (tri_phase + 1 >= 3);
    if (closes) begin
      tri_phase = 0;
      for (i = 0; i < 3; i++) begin
        dv0[i] = 128'(held_pos[3+i]) - 128'(held_pos[i]);
        dv1[i] = 128'(p[i]) - 128'(held_pos[i]);
      end
      for (i = 0; i < 2; i++) begin
        dt0[i] = 128'(held_tex[2+i]) - 128'(held_tex[i]);
        dt1[i] = 128'(t[i]) - 128'(held_tex[i]);
      end
      det = dt0[0] * dt1[1] - dt1[0] * dt0[1];
      for (i = 0; i < 3; i++) begin
        tv[i] = dv0[i] * dt1[1] - dv1[i] * dt0[1];
        bv[i] = dv1[i] * dt0[0] - dv0[i] * dt1[0];
      end
      flip = !(det < 0);
      unit_vector(tv[0], tv[1], tv[2], flip, f.tx, f.ty, f.tz, ok_t);
      unit_vector(bv[0], bv[1], bv[2], flip, f.bx, f.by, f.bz, ok_b);
      if (det == 0 || !ok_t || !ok_b) f = '{degen: 1'b1, default: '0};
    end else begin
      tri_phase++;
    end
    for (i = 0; i < 3; i++) begin
      held_pos[i] = held_pos[3+i];
      held_pos[3+i] = p[i];
    end
    for (i = 0; i < 2; i++) begin
      held_tex[i] = held_tex[2+i];
      held_tex[2+i] = t[i];
    end
  endtask

  task automatic add_vertex(input logic ns, input logic signed [CW-1:0] px, py, pz, tu, tv);
    vertex_t vx;
    vx = '{ns: ns, px: px, py: py, pz: pz, tu: tu, tv: tv, typed: 1'b0,
           want: '{default: '0}};
    vertices.insert(vertices.size(), vx);
  endtask

  // typed expectation on the closing vertex of the last row added
  task automatic expect_last(input logic signed [OW-1:0] tx, ty, tz, bx, by, bz, input logic dg);
    vertices[vertices.size()-1].typed = 1'b1;
    vertices[vertices.size()-1].want = '{tx: tx, ty: ty, tz: tz, bx: bx, by: by, bz: bz,
                                         degen: dg};
  endtask

  function automatic logic signed [CW-1:0] draw_coord(input int cls);
    case (cls)
      0: draw_coord = $urandom;
      1: draw_coord = $signed($urandom_range(0, 4000)) - 2000;
      2: draw_coord = ($signed($urandom_range(0, 200)) - 100) <<< 16;
      default: begin
        case ($urandom_range(0, 3))
          0: draw_coord = 32'sh7fffffff;
          1: draw_coord = 32'sh80000000;
          2: draw_coord = '0;
          default: draw_coord = $urandom;
        endcase
      end
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic signed [OW-1:0] got, wanted);
    $display("frame mismatch on %s: got %0d, expected %0d", field, got, wanted);
    mismatches++;
  endtask

  // directed table, then random triangles and single vertices
  task automatic build_stimulus();
    logic signed [CW-1:0] one, mx, mn, u0, v0;
    int i, cls;
    bit degen_uv;
    one = 32'sh00010000;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    // vertices before any shape run against the reset history
    add_vertex(1'b0, mx, mn, mx, mn, mx);
    add_vertex(1'b0, mn, mx, mn, mx, mn);
    add_vertex(1'b0, 32'sh12345678, -32'sh0abcdef0, 32'sh00000001, 32'sh00003000, mx);
    // unit triangle, positive determinant
    add_vertex(1'b1, 0, 0, 0, 0, 0);
    add_vertex(1'b0, one, 0, 0, one, 0);
    add_vertex(1'b0, 0, one, 0, 0, one);
    expect_last(-16384, 0, 0, 0, -16384, 0, 1'b0);
    // negative determinant
    add_vertex(1'b1, 0, 0, 0, 0, 0);
    add_vertex(1'b0, one, 0, 0, 0, one);
    add_vertex(1'b0, 0, one, 0, one, 0);
    expect_last(0, -16384, 0, -16384, 0, 0, 1'b0);
    // zero uv determinant
    add_vertex(1'b1, one, 0, 0, one, one);
    add_vertex(1'b0, 0, one, 0, one, one);
    add_vertex(1'b0, 0, 0, one, one, one);
    expect_last(0, 0, 0, 0, 0, 0, 1'b1);
    // all positions equal, so both vectors vanish
    add_vertex(1'b1, one, one, one, 0, 0);
    add_vertex(1'b0, one, one, one, one, 0);
    add_vertex(1'b0, one, one, one, 0, one);
    expect_last(0, 0, 0, 0, 0, 0, 1'b1);
    // full-range extremes
    add_vertex(1'b1, mn, mn, mx, mx, mn);
    add_vertex(1'b0, mx, mn, mn, mn, mx);
    add_vertex(1'b0, mn, mx, mn, mn, mn);
    // new shape in the middle of a triangle
    add_vertex(1'b1, one, 0, 0, 0, 0);
    add_vertex(1'b0, 0, one, 0, one, 0);
    add_vertex(1'b1, 0, 0, one, 0, one);
    add_vertex(1'b0, -one, one, 0, one, one);
    add_vertex(1'b0, one, -one, one, -one, one);

    i = 0;
    while (i < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) != 0) begin
        cls = $urandom_range(0, 3);
        degen_uv = ($urandom_range(0, 15) == 0);
        u0 = draw_coord(cls);
        v0 = draw_coord(cls);
        add_vertex(1'b1, draw_coord(cls), draw_coord(cls), draw_coord(cls), u0, v0);
        add_vertex(1'b0, draw_coord(cls), draw_coord(cls), draw_coord(cls),
                   degen_uv ? u0 : draw_coord(cls), degen_uv ? v0 : draw_coord(cls));
        add_vertex(1'b0, draw_coord(cls), draw_coord(cls), draw_coord(cls),
                   degen_uv ? u0 : draw_coord(cls), degen_uv ? v0 : draw_coord(cls));
        i += 3;
      end else begin
        cls = $urandom_range(0, 3);
        add_vertex(1'($urandom_range(0, 1)), draw_coord(cls), draw_coord(cls),
                   draw_coord(cls), draw_coord(cls), draw_coord(cls));
        i++;
      end
    end
  endtask

  // input side: random gaps, valid held across back-to-back transactions
  initial begin
    vertex_t vx;
    frame_t  f;
    bit      closes;
    int      gap, quiet;
    for (int i = 0; i < 6; i++) held_pos[i] = '0;
    for (int i = 0; i < 4; i++) held_tex[i] = '0;
    tri_phase = 0;
    build_stimulus();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    quiet = 0;
    while (vertices.size() != 0) begin
      vx = vertices.pop_front();
      if (quiet == 0 && $urandom_range(0, 31) == 0) quiet = $urandom_range(10, 60);
      gap = (quiet > 0) ? 0 : $urandom_range(0, 7);
      if (quiet > 0) quiet--;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      new_shape <= vx.ns;
      pos_x <= vx.px; pos_y <= vx.py; pos_z <= vx.pz;
      tex_u <= vx.tu; tex_v <= vx.tv;
      do @(posedge clk); while (in_stall);
      // transaction accepted at this edge
      tangent_frame_of(vx, closes, f);
      if (closes) frames_due.insert(frames_due.size(), vx.typed ? vx.want : f);
    end
    in_valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // output side: random stall before each transaction, then compare
  initial begin
    frame_t e;
    int     hold, quiet;
    quiet = 0;
    forever begin
      if (quiet == 0 && $urandom_range(0, 15) == 0) quiet = $urandom_range(5, 20);
      hold = (quiet > 0) ? 0 : $urandom_range(0, 7);
      if (quiet > 0) quiet--;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      if (frames_due.size() == 0) begin
        $display("frame with no vertex triangle waiting");
        mismatches++;
      end else begin
        e = frames_due.pop_front();
        if (tan_x !== e.tx) report_mismatch("tangent_x", tan_x, e.tx);
        if (tan_y !== e.ty) report_mismatch("tangent_y", tan_y, e.ty);
        if (tan_z !== e.tz) report_mismatch("tangent_z", tan_z, e.tz);
        if (bit_x !== e.bx) report_mismatch("bitangent_x", bit_x, e.bx);
        if (bit_y !== e.by) report_mismatch("bitangent_y", bit_y, e.by);
        if (bit_z !== e.bz) report_mismatch("bitangent_z", bit_z, e.bz);
        if (degenerate !== e.degen)
          report_mismatch("degenerate", OW'(degenerate), OW'(e.degen));
      end
    end
  end

  // end of run
  initial begin
    wait (stimulus_done);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (frames_due.size() != 0) begin
      $display("%0d frames never arrived", frames_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("[triangle_tangent_frame] OK");
    end else begin
      $display("[triangle_tangent_frame] ERROR");
    end
    $finish;
  end

endmodule
